### hdl/ior_pkg.sv
// Shared types and constants for the in-order release reorder block.
package ior_pkg;

    localparam int SEQ_IN_W  = 8;
    localparam int SEQ_OUT_W = 7;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    // One request after range classification.
    typedef struct packed {
        logic                 range_ok;
        logic [SEQ_OUT_W-1:0] seq;
    } t_item;

    // One result as it leaves the block.
    typedef struct packed {
        logic [SEQ_OUT_W-1:0] released_seq;
        logic                 last_of_run;
        logic                 status;
    } t_result;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

endpackage

### hdl/in_order_release_reorder.sv
// Top level of the in-order release reorder buffer.
//
// Usage: sequence numbers 1..SEQ_COUNT arrive on the input channel in any
// order, one per request (i_in_valid / o_in_stall, payload i_seq_number).
// Results leave on the output channel (o_out_valid / i_out_stall) with
// the released number, a last-of-run flag and a status bit.
// A number that is the next one expected is released at once, followed in
// order by every consecutive number that already arrived; the final result
// of that run carries o_last_of_run. A number that arrives early is held
// and gives no result. A duplicate or out-of-range number gives a single
// rejected result with a released value of zero.
// With the queue empty and the output free, a rejected result passes the
// front register, the queue and the output register; a released run passes
// the back stage's run state as well. The back stage takes a queued number
// only while idle; a run drains, unless stalled, at the pace of the single
// arrival bit lookup the drain loop performs each cycle.
// Reset (synchronous, active low) clears the arrival map, sets the expected
// number to one and empties the queue and output register. While the
// receiver stalls, the output result holds and the queue keeps taking
// requests until it fills; o_in_stall rises when the front holds one more.
module in_order_release_reorder
    import ior_pkg::*;
#(
    parameter int SEQ_COUNT = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [SEQ_IN_W-1:0]  i_seq_number,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [SEQ_OUT_W-1:0] o_released_seq,
    output logic                 o_last_of_run,
    output logic                 o_status
);

    logic    q_push;
    t_item   q_in_item;
    logic    q_full;
    logic    q_pop;
    logic    q_valid;
    t_item   q_head;
    t_result out_result;

    // The front registers each request and checks it is within range.
    ior_front #(
        .SEQ_COUNT (SEQ_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_seq_number (i_seq_number),
        .i_q_full     (q_full),
        .o_push       (q_push),
        .o_item       (q_in_item)
    );

    // The queue lets the front keep accepting while a run drains.
    ior_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_head)
    );

    // The back owns the arrival map and drains runs one number a cycle unless stalled.
    ior_back #(
        .SEQ_COUNT (SEQ_COUNT)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_result  (out_result)
    );

    assign o_released_seq = out_result.released_seq;
    assign o_last_of_run  = out_result.last_of_run;
    assign o_status       = out_result.status;

`ifndef SYNTHESIS
    // Nothing is presented on the output in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A rejected result always reads as zero and closes its run.
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_REJECTED)) |->
            (o_last_of_run && (o_released_seq == '0)))
        else $error("malformed rejected result");

    // A released number is always inside the valid range.
    a_release_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_RELEASED)) |->
            ((o_released_seq != '0) &&
             (o_released_seq <= SEQ_OUT_W'(SEQ_COUNT))))
        else $error("released number out of range");
`endif

endmodule

### hdl/ior_front.sv
// Front stage: registers an incoming request and classifies its range.
module ior_front
    import ior_pkg::*;
#(
    parameter int SEQ_COUNT = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SEQ_IN_W-1:0] i_seq_number,
    input  logic                i_q_full,
    output logic                o_push,
    output t_item               o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign o_stall = r_valid && i_q_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_q_full;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.range_ok <= (i_seq_number != '0) &&
                               (i_seq_number <= SEQ_IN_W'(SEQ_COUNT));
            r_item.seq      <= i_seq_number[SEQ_OUT_W-1:0];
        end
    end

endmodule

### hdl/ior_fifo.sv
// Short queue of classified requests between the front and back stages.
module ior_fifo
    import ior_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/ior_back.sv
// Back stage: arrival map, expected number, run drain and output register.
module ior_back
    import ior_pkg::*;
#(
    parameter int SEQ_COUNT = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam int IDX_W = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;

    t_back_state          r_state;
    t_back_state          n_state;
    logic [SEQ_OUT_W-1:0] r_next;
    logic [SEQ_OUT_W-1:0] n_next;
    logic [SEQ_COUNT-1:0] r_arrived;
    logic [SEQ_COUNT-1:0] n_arrived;
    logic                 r_out_valid;
    t_result              r_out;

    logic                 out_ready;
    logic [SEQ_OUT_W-1:0] rd_num;
    logic [SEQ_OUT_W-1:0] rd_num_m1;
    logic [IDX_W-1:0]     rd_idx;
    logic                 rd_bit;
    logic                 reject;
    logic                 has_more;
    logic                 emit;
    t_result              res;

    assign out_ready = !r_out_valid || !i_stall;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // One arrival bit is looked at per cycle: the popped number when idle,
    // the number after the current one while a run drains.
    assign rd_num    = (r_state == BK_IDLE) ? i_q_item.seq : r_next;
    assign rd_num_m1 = rd_num - 1'b1;
    assign rd_idx    = rd_num_m1[IDX_W-1:0];
    assign rd_bit    = r_arrived[rd_idx];

    assign reject   = !i_q_item.range_ok || (i_q_item.seq < r_next) || rd_bit;
    assign has_more = (r_next <= SEQ_OUT_W'(SEQ_COUNT)) && rd_bit;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_ready && !reject && (i_q_item.seq == r_next)) begin
                    n_state = BK_RUN;
                end
            end
            BK_RUN: begin
                if (out_ready && !has_more) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        o_pop            = 1'b0;
        emit             = 1'b0;
        res.released_seq = '0;
        res.last_of_run  = 1'b1;
        res.status       = STATUS_REJECTED;
        n_next           = r_next;
        n_arrived        = r_arrived;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && out_ready) begin
                    o_pop = 1'b1;
                    if (reject) begin
                        emit = 1'b1;
                    end else if (i_q_item.seq != r_next) begin
                        n_arrived[rd_idx] = 1'b1;
                    end else begin
                        n_next = r_next + 1'b1;
                    end
                end
            end
            BK_RUN: begin
                if (out_ready) begin
                    emit             = 1'b1;
                    res.released_seq = r_next - 1'b1;
                    res.last_of_run  = !has_more;
                    res.status       = STATUS_RELEASED;
                    if (has_more) begin
                        n_arrived[rd_idx] = 1'b0;
                        n_next            = r_next + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_next      <= SEQ_OUT_W'(1);
            r_arrived   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next    <= n_next;
            r_arrived <= n_arrived;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

endmodule

### tb/tb.sv
// Self-checking testbench for the in-order release reorder buffer.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ior_pkg::*;

    localparam int SEQ_COUNT = 64;

    // The slowest correct run ends well below this. The budget allows for
    // every request to wait out a long sender gap, and for every result to
    // wait out a long receiver stall.
    localparam realtime RUN_LIMIT = 5ms;

    // Clock, reset and the signals that the testbench drives. Every input
    // of the block starts at a known value.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [SEQ_IN_W-1:0] in_seq = '0;
    logic out_stall = 1'b0;

    logic in_stall;
    logic out_valid;
    logic [SEQ_OUT_W-1:0] out_released_seq;
    logic out_last_of_run;
    logic out_status;

    // Our own copy of the block's state: one arrival bit per number and the
    // number that is due next.
    logic [SEQ_COUNT:1] arrival_seen = '0;
    int unsigned next_seq = 1;

    // Results that the accepted requests must still cause, oldest first.
    t_result pending_results[$];

    int unsigned fail_count = 0;

    // Idling controls. Each side can be told to stop idling for a while, so
    // that some stretches run at full rate.
    logic gap_enable = 1'b1;
    logic stall_enable = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_roll;

    in_order_release_reorder #(
        .SEQ_COUNT(SEQ_COUNT)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_seq_number   (in_seq),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_released_seq (out_released_seq),
        .o_last_of_run  (out_last_of_run),
        .o_status       (out_status)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Only the first ten failures are printed. The rest are counted, so that
    // the log stays short when something goes badly wrong.
    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%t: %s", $realtime, msg);
        end
    endfunction

    function automatic void push_result(int unsigned seq, logic last, logic status);
        t_result r;
        r.released_seq = seq[SEQ_OUT_W-1:0];
        r.last_of_run = last;
        r.status = status;
        pending_results.push_back(r);
    endfunction

    // Works out what one accepted request must cause and updates our copy of
    // the state. A number that is out of range, already released or already
    // waiting is rejected with a single result and changes nothing. A new
    // number that is not due yet is only marked. The number that is due is
    // released together with the run of marked numbers right above it.
    function automatic void predict_arrival(logic [SEQ_IN_W-1:0] value);
        int unsigned run_end;
        if (value < 1 || value > SEQ_COUNT || value < next_seq || arrival_seen[value]) begin
            push_result(0, 1'b1, STATUS_REJECTED);
        end else if (value != next_seq) begin
            arrival_seen[value] = 1'b1;
        end else begin
            run_end = value;
            while (run_end < SEQ_COUNT && arrival_seen[run_end + 1]) begin
                run_end++;
            end
            for (int unsigned k = value; k <= run_end; k++) begin
                arrival_seen[k] = 1'b0;
                push_result(k, k == run_end, STATUS_RELEASED);
            end
            next_seq = run_end + 1;
        end
    endfunction

    function automatic void check_result();
        t_result want;
        if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected result: seq %0d last %0b status %0b",
                                   out_released_seq, out_last_of_run, out_status));
        end else begin
            want = pending_results.pop_front();
            if (out_released_seq !== want.released_seq ||
                out_last_of_run !== want.last_of_run ||
                out_status !== want.status) begin
                note_failure($sformatf(
                    "result mismatch: expected seq %0d last %0b status %0b, got %0d %0b %0b",
                    want.released_seq, want.last_of_run, want.status,
                    out_released_seq, out_last_of_run, out_status));
            end
        end
    endfunction

    // Both handshakes are observed at the rising edge, before the block's
    // registers move. The result is checked first; its expectation always
    // came from an earlier request, since a request passes the front and
    // output registers before its result shows, so this order is safe.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                check_result();
            end
            if (in_valid && !in_stall) begin
                predict_arrival(in_seq);
            end
        end
    end

    // Receiver stalls: mostly short, sometimes long, with free stretches in
    // between so that results leave on every phase of a drain.
    always @(negedge clk) begin
        if (!stall_enable) begin
            out_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 50) begin
                out_stall = 1'b0;
                stall_left = $urandom_range(0, 15);
            end else if (stall_roll < 92) begin
                out_stall = 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall = 1'b1;
                stall_left = $urandom_range(8, 40);
            end
        end
    end

    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!gap_enable || roll < 55) begin
            return 0;
        end else if (roll < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Every 40 requests each side may turn its idling on or off, so the run
    // holds full-rate stretches as well as uneven ones.
    function automatic void reshuffle_idling();
        gap_enable = ($urandom_range(0, 3) != 0);
        stall_enable = ($urandom_range(0, 3) != 0);
    endfunction

    // Sends one request. Inputs change only at the falling edge. When there
    // is no gap, valid simply stays high for the next request. The payload
    // is held until the request is taken.
    task automatic send_seq(input logic [SEQ_IN_W-1:0] value);
        int unsigned gap;
        gap = idle_length();
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_seq = value;
        do begin
            @(posedge clk);
        end while (in_stall);
    endtask

    // Holds the sender off until every expected result has come out.
    task automatic wait_results_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Zero, just above the range, and values that set the top bits.
    task automatic test_out_of_range();
        send_seq(8'd0);
        send_seq(8'(SEQ_COUNT + 1));
        send_seq(8'h80);
        send_seq(8'hFF);
    endtask

    // Numbers that arrive early are held and then drained as runs of three,
    // two and six. Six itself is released alone. The top number is held
    // until the random part reaches it.
    task automatic test_early_arrivals();
        send_seq(8'd3);
        send_seq(8'd2);
        send_seq(8'd1);
        send_seq(8'd5);
        send_seq(8'd4);
        send_seq(8'd6);
        send_seq(8'd9);
        send_seq(8'd10);
        send_seq(8'd11);
        send_seq(8'd12);
        send_seq(8'd8);
        send_seq(8'd7);
        send_seq(8'(SEQ_COUNT));
    endtask

    // Numbers that are already released, a number that is still held, and
    // a number repeated right after its own release.
    task automatic test_duplicates();
        send_seq(8'd2);
        send_seq(8'd10);
        send_seq(8'(SEQ_COUNT));
        send_seq(8'd13);
        send_seq(8'd13);
        send_seq(8'd1);
    endtask

    function automatic logic [SEQ_IN_W-1:0] pick_noise();
        int unsigned k;
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(SEQ_COUNT + 1, 255));
            2: begin
                if (next_seq > 1) begin
                    return 8'($urandom_range(1, next_seq - 1));
                end
                return 8'd0;
            end
            default: begin
                // A number that is waiting, if a few tries find one.
                for (int tries = 0; tries < 16; tries++) begin
                    k = $urandom_range(1, SEQ_COUNT);
                    if (arrival_seen[k]) begin
                        return 8'(k);
                    end
                end
                return 8'd0;
            end
        endcase
    endfunction

    // Sends every number still missing, in random order, with a mix of
    // mostly rejected requests in between. The number that is due is moved
    // into the last third, so that a long run builds up before it drains.
    task automatic test_random_round();
        int unsigned order[$];
        int unsigned pos;
        int unsigned swap_pos;
        int unsigned held;
        int unsigned noise_count;
        int unsigned sent;
        sent = 0;
        for (int unsigned k = next_seq; k <= SEQ_COUNT; k++) begin
            if (!arrival_seen[k]) begin
                order.push_back(k);
            end
        end
        for (int i = order.size() - 1; i > 0; i--) begin
            pos = $urandom_range(0, i);
            held = order[i];
            order[i] = order[pos];
            order[pos] = held;
        end
        for (int i = 0; i < order.size(); i++) begin
            if (order[i] == next_seq) begin
                pos = i;
            end
        end
        swap_pos = $urandom_range(2 * order.size() / 3, order.size() - 1);
        held = order[swap_pos];
        order[swap_pos] = order[pos];
        order[pos] = held;

        foreach (order[i]) begin
            noise_count = $urandom_range(0, 10);
            repeat (noise_count) begin
                if (sent % 40 == 0) begin
                    reshuffle_idling();
                end
                send_seq(pick_noise());
                sent++;
            end
            send_seq(8'(order[i]));
            sent++;
        end
    endtask

    // With every number released, each request must come back rejected.
    task automatic test_all_released();
        for (int i = 0; i < 170; i++) begin
            if (i % 40 == 0) begin
                reshuffle_idling();
            end
            send_seq(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_out_of_range();
        test_early_arrivals();
        test_duplicates();
        wait_results_drained();
        test_random_round();
        wait_results_drained();
        test_all_released();

        // Let the last results come out, then allow a margin for anything
        // stray that the block might still send.
        wait_results_drained();
        repeat (50) @(posedge clk);

        if (pending_results.size() != 0) begin
            note_failure($sformatf("%0d expected results never came",
                                   pending_results.size()));
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #RUN_LIMIT;
        $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hdl/ior_pkg.sv
hdl/ior_front.sv
hdl/ior_fifo.sv
hdl/ior_back.sv
hdl/in_order_release_reorder.sv
tb/tb.sv
